@@ hw/rtl/wcg_pkg.sv @@
// Shared types and constants for the wheel candidate generator.
package wcg_pkg;

  localparam int RES_W      = 5;
  localparam int CAND_W     = 48;
  localparam int CFG_W      = 4;
  localparam int STEP_LIMIT = 64;
  localparam int TABLE_LEN  = 8;

  localparam logic [RES_W-1:0] WHEEL_TABLE [TABLE_LEN] = '{
    5'd2, 5'd3, 5'd5, 5'd7, 5'd11, 5'd13, 5'd17, 5'd19
  };

  // Running tests handed down the row of cells.
  typedef struct packed {
    logic coprime;
    logic last;
  } chain_t;

  // Control sent from the sequencer to every cell.
  typedef struct packed {
    logic clear;
    logic step;
  } cell_ctrl_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

endpackage

@@ hw/rtl/wheel_candidate_generator_top.sv @@
// Top level of the wheel candidate generator: sequencer, value counter and cell row.
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_stall_o   restart_i
//   out      output     out_valid_o / out_stall_i candidate_o, last_in_round_o, overflow_o
//   cfg      input      cfg_we_i                  cfg_wdata_i
//
// An item is accepted in the idle state. The single-step counter and the row of residue
// cells then advance the running value by one each cycle until every active cell is
// nonzero, the step budget runs out or the top of the range is reached, and the result
// is then loaded into the output register.
// Reset puts the value at 1, every residue at 1, clears the exhausted flag and loads a
// wheel of four primes (or MAX_WHEEL_PRIMES if smaller).
// A finished result waits in the output register while the next item is accepted; the
// sequencer holds its last step while the output register stays stalled.
module wheel_candidate_generator_top #(
  parameter int MAX_WHEEL_PRIMES = 8,
  parameter int VALUE_BITS       = 48
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [wcg_pkg::CFG_W-1:0]   cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        restart_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [wcg_pkg::CAND_W-1:0]  candidate_o,
  output logic                        last_in_round_o,
  output logic                        overflow_o
);
  import wcg_pkg::*;

  localparam int CNT_W   = $clog2(MAX_WHEEL_PRIMES + 1);
  localparam int STEP_W  = $clog2(STEP_LIMIT + 1);
  localparam int RESET_N = (MAX_WHEEL_PRIMES < 4) ? MAX_WHEEL_PRIMES : 4;
  localparam int EXT_W   = (VALUE_BITS > CAND_W) ? VALUE_BITS : CAND_W;

  // Configured wheel size, already clamped into 1 .. MAX_WHEEL_PRIMES.
  logic [CNT_W-1:0] nprimes_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nprimes_q <= CNT_W'(RESET_N);
    end else if (cfg_we_i) begin
      if (cfg_wdata_i == '0) begin
        nprimes_q <= CNT_W'(1);
      end else if (32'(cfg_wdata_i) > MAX_WHEEL_PRIMES) begin
        nprimes_q <= CNT_W'(MAX_WHEEL_PRIMES);
      end else begin
        nprimes_q <= CNT_W'(cfg_wdata_i);
      end
    end
  end

  // Row of residue cells. The chain runs from cell 0 to the last cell and
  // reports whether the running value is coprime to, and one below a multiple
  // of, every active prime.
  cell_ctrl_t cell_ctrl;
  chain_t     chain [MAX_WHEEL_PRIMES+1];

  assign chain[0] = '{coprime: 1'b1, last: 1'b1};

  for (genvar k = 0; k < MAX_WHEEL_PRIMES; k++) begin : g_cell
    logic active;
    assign active = (CNT_W'(k) < nprimes_q);
    wcg_cell #(
      .PRIME (WHEEL_TABLE[k])
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (cell_ctrl),
      .active_i (active),
      .chain_i  (chain[k]),
      .chain_o  (chain[k+1])
    );
  end

  chain_t chain_end;
  assign chain_end = chain[MAX_WHEEL_PRIMES];

  // Sequencer state.
  state_e              state_q, state_d;
  logic                first_q, first_d;
  logic [STEP_W-1:0]   steps_q, steps_d;
  logic [VALUE_BITS-1:0] cur_q, cur_d;
  logic                exh_q, exh_d;

  // Output register.
  logic                out_valid_q, out_valid_d;
  logic [CAND_W-1:0]   out_cand_q, out_cand_d;
  logic                out_last_q, out_last_d;
  logic                out_ovf_q, out_ovf_d;

  logic                out_free;
  logic                cur_max;
  logic [EXT_W-1:0]    cur_ext;
  logic [EXT_W-1:0]    max_ext;

  assign out_free = !out_valid_q || !out_stall_i;
  assign cur_max  = &cur_q;
  assign cur_ext  = EXT_W'(cur_q);
  assign max_ext  = EXT_W'({VALUE_BITS{1'b1}});

  always_comb begin
    state_d     = state_q;
    first_d     = first_q;
    steps_d     = steps_q;
    cur_d       = cur_q;
    exh_d       = exh_q;
    cell_ctrl   = '0;
    out_valid_d = out_valid_q && out_stall_i;
    out_cand_d  = out_cand_q;
    out_last_d  = out_last_q;
    out_ovf_d   = out_ovf_q;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (restart_i) begin
            cur_d           = VALUE_BITS'(1);
            exh_d           = 1'b0;
            cell_ctrl.clear = 1'b1;
          end
          first_d = 1'b1;
          steps_d = '0;
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (!first_q && (chain_end.coprime || steps_q == STEP_W'(STEP_LIMIT))) begin
          // The value just reached is a candidate, or the step budget ran out.
          if (out_free) begin
            out_valid_d = 1'b1;
            out_cand_d  = cur_ext[CAND_W-1:0];
            out_last_d  = chain_end.last;
            out_ovf_d   = 1'b0;
            state_d     = ST_IDLE;
          end
        end else if (exh_q || cur_max) begin
          // The top of the range is reached: the value saturates.
          if (out_free) begin
            exh_d       = 1'b1;
            out_valid_d = 1'b1;
            out_cand_d  = max_ext[CAND_W-1:0];
            out_last_d  = 1'b0;
            out_ovf_d   = 1'b1;
            state_d     = ST_IDLE;
          end
        end else begin
          cur_d          = cur_q + VALUE_BITS'(1);
          cell_ctrl.step = 1'b1;
          steps_d        = steps_q + STEP_W'(1);
          first_d        = 1'b0;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      first_q     <= 1'b1;
      steps_q     <= '0;
      cur_q       <= VALUE_BITS'(1);
      exh_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      first_q     <= first_d;
      steps_q     <= steps_d;
      cur_q       <= cur_d;
      exh_q       <= exh_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_cand_q <= out_cand_d;
    out_last_q <= out_last_d;
    out_ovf_q  <= out_ovf_d;
  end

  assign in_stall_o      = (state_q != ST_IDLE);
  assign out_valid_o     = out_valid_q;
  assign candidate_o     = out_cand_q;
  assign last_in_round_o = out_last_q;
  assign overflow_o      = out_ovf_q;

`ifndef NO_ASSERTIONS
  // The exhausted flag is only ever set with the value at the top of its range.
  a_exh_at_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exh_q |-> cur_max)
    else $error("exhausted flag set below the top of the range");

  // An overflow result never carries the end-of-round flag.
  a_ovf_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_ovf_q) |-> !out_last_q)
    else $error("overflow result flagged as last in round");

  // The step counter never passes its budget.
  a_step_budget: assert property (@(posedge clk_i) disable iff (!rst_ni)
    steps_q <= STEP_W'(STEP_LIMIT))
    else $error("step counter passed its limit");

  // A new result appears only as the sequencer leaves its run state.
  a_load_from_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_RUN && state_q == ST_IDLE))
    else $error("result loaded outside a run");

  // Once a step has been taken the running value is above one.
  a_value_moved: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN && !first_q) |-> (cur_q != VALUE_BITS'(1)))
    else $error("running value did not advance");
`endif

endmodule

@@ hw/rtl/wcg_cell.sv @@
// One wheel cell: residue of the running value modulo one prime.
module wcg_cell #(
  parameter logic [wcg_pkg::RES_W-1:0] PRIME = 5'd2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  wcg_pkg::cell_ctrl_t ctrl_i,
  input  logic                active_i,
  input  wcg_pkg::chain_t     chain_i,
  output wcg_pkg::chain_t     chain_o
);
  import wcg_pkg::*;

  localparam logic [RES_W-1:0] TOP = PRIME - RES_W'(1);

  logic [RES_W-1:0] res_q, res_d;

  always_comb begin
    res_d = res_q;
    if (ctrl_i.clear) begin
      res_d = RES_W'(1);
    end else if (ctrl_i.step) begin
      res_d = (res_q == TOP) ? '0 : res_q + RES_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= RES_W'(1);
    end else begin
      res_q <= res_d;
    end
  end

  // An inactive cell lies beyond the configured wheel and passes the chain on.
  always_comb begin
    chain_o = chain_i;
    if (active_i) begin
      chain_o.coprime = chain_i.coprime & (res_q != '0);
      chain_o.last    = chain_i.last & (res_q == TOP);
    end
  end

endmodule

@@ verif/tb_wheel_candidate_generator_top.sv @@
// Self-checking testbench for the wheel candidate generator top level.
`timescale 1ns / 1ps

module tb_wheel_candidate_generator_top;
  import wcg_pkg::*;

  localparam int MAX_PRIMES = 8;
  localparam logic [CAND_W-1:0] VALUE_MAX = {CAND_W{1'b1}};
  localparam int CYCLE_LIMIT = 600000;
  localparam int PHASE_COUNT = 8;
  localparam int PHASE_ITEMS = 105;
  localparam int HOLD_CYCLES = 250;
  localparam int DRAIN_CYCLES = 60;
  localparam int PRINT_CAP = 20;

  // One expected result of the block.
  typedef struct packed {
    logic [CAND_W-1:0] candidate;
    logic              last;
    logic              ovf;
  } wheel_result_t;

  // One row of the directed table: an optional wheel write ahead of the item,
  // the restart bit, and where obvious the result typed in by hand.
  typedef struct packed {
    bit                wr;
    logic [CFG_W-1:0]  wval;
    bit                rst;
    bit                typed;
    logic [CAND_W-1:0] cand;
    bit                last;
  } dir_row_t;

  localparam int DIR_ROWS = 25;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [CFG_W-1:0]  cfg_wdata_i;
  logic              in_valid_i;
  logic              in_stall_o;
  logic              restart_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [CAND_W-1:0] candidate_o;
  logic              last_in_round_o;
  logic              overflow_o;

  // Predictor state: running value, residue per wheel prime, exhausted flag
  // and the wheel size register as last written.
  logic [CAND_W-1:0] run_value;
  logic [RES_W-1:0]  run_res [TABLE_LEN];
  bit                run_done;
  logic [CFG_W-1:0]  wheel_cfg;

  wheel_result_t expected_results [$];
  int unsigned   mismatch_count;
  int unsigned   cycle_count;
  bit            hold_requested;

  dir_row_t dir_rows [DIR_ROWS] = '{
    // Reset wheel of four primes: 11, 13, 17, then a restart back to 11.
    '{1'b0, 4'd0,  1'b0, 1'b1, 48'd11, 1'b0},
    '{1'b0, 4'd0,  1'b0, 1'b1, 48'd13, 1'b0},
    '{1'b0, 4'd0,  1'b0, 1'b1, 48'd17, 1'b0},
    '{1'b0, 4'd0,  1'b1, 1'b1, 48'd11, 1'b0},
    '{1'b0, 4'd0,  1'b0, 1'b0, 48'd0,  1'b0},
    // A zero register acts as a one-prime wheel, applied mid-sequence.
    '{1'b1, 4'd0,  1'b0, 1'b0, 48'd0,  1'b0},
    '{1'b0, 4'd0,  1'b1, 1'b1, 48'd3,  1'b1},
    '{1'b0, 4'd0,  1'b0, 1'b1, 48'd5,  1'b1},
    // The largest register value clamps to eight primes.
    '{1'b1, 4'd15, 1'b1, 1'b1, 48'd23, 1'b0},
    '{1'b0, 4'd0,  1'b0, 1'b1, 48'd29, 1'b0},
    '{1'b1, 4'd2,  1'b1, 1'b1, 48'd5,  1'b1},
    '{1'b0, 4'd0,  1'b0, 1'b1, 48'd7,  1'b0},
    '{1'b0, 4'd0,  1'b0, 1'b1, 48'd11, 1'b1},
    '{1'b1, 4'd1,  1'b0, 1'b0, 48'd0,  1'b0},
    // Three primes: walk up to 29, which closes the block of 30.
    '{1'b1, 4'd3,  1'b1, 1'b1, 48'd7,  1'b0},
    '{1'b0, 4'd0,  1'b0, 1'b0, 48'd0,  1'b0},
    '{1'b0, 4'd0,  1'b0, 1'b0, 48'd0,  1'b0},
    '{1'b0, 4'd0,  1'b0, 1'b0, 48'd0,  1'b0},
    '{1'b0, 4'd0,  1'b0, 1'b0, 48'd0,  1'b0},
    '{1'b0, 4'd0,  1'b0, 1'b0, 48'd0,  1'b0},
    '{1'b0, 4'd0,  1'b0, 1'b0, 48'd0,  1'b0},
    '{1'b1, 4'd9,  1'b0, 1'b0, 48'd0,  1'b0},
    '{1'b1, 4'd8,  1'b1, 1'b1, 48'd23, 1'b0},
    '{1'b0, 4'd0,  1'b0, 1'b0, 48'd0,  1'b0},
    '{1'b1, 4'd4,  1'b1, 1'b1, 48'd11, 1'b0}
  };

  wheel_candidate_generator_top #(
    .MAX_WHEEL_PRIMES(MAX_PRIMES),
    .VALUE_BITS      (CAND_W)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .restart_i      (restart_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .candidate_o    (candidate_o),
    .last_in_round_o(last_in_round_o),
    .overflow_o     (overflow_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Puts the running value back at one with every residue at one.
  function automatic void clear_wheel();
    run_value = 1;
    for (int k = 0; k < TABLE_LEN; k++) run_res[k] = 1;
    run_done = 1'b0;
  endfunction

  // Steps the running value until it is coprime to the active wheel primes, the step budget
  // runs out or the range ends, and returns the result the block must produce for this item.
  function automatic wheel_result_t advance_wheel(bit restart);
    wheel_result_t    r;
    int               n;
    bit               coprime;
    bit               ends;
    logic [RES_W-1:0] res;
    n = (wheel_cfg == 0) ? 1 : ((wheel_cfg > MAX_PRIMES) ? MAX_PRIMES : int'(wheel_cfg));
    if (restart) clear_wheel();
    if (!run_done) begin
      for (int i = 0; i < STEP_LIMIT; i++) begin
        if (run_value >= VALUE_MAX) begin
          run_done = 1'b1;
          break;
        end
        run_value = run_value + 1;
        for (int k = 0; k < TABLE_LEN; k++) begin
          res = run_res[k] + 1;
          run_res[k] = (res >= WHEEL_TABLE[k]) ? '0 : res;
        end
        coprime = 1'b1;
        for (int k = 0; k < n; k++) if (run_res[k] == 0) coprime = 1'b0;
        if (coprime) break;
      end
    end
    if (run_done) begin
      r.candidate = VALUE_MAX;
      r.last = 1'b0;
      r.ovf = 1'b1;
      return r;
    end
    ends = 1'b1;
    for (int k = 0; k < n; k++) if (run_res[k] != WHEEL_TABLE[k] - 1) ends = 1'b0;
    r.candidate = run_value;
    r.last = ends;
    r.ovf = 1'b0;
    return r;
  endfunction

  // Prints one line per mismatch (up to a cap) and counts every one.
  task automatic report_mismatch(string msg);
    if (mismatch_count < PRINT_CAP) $display("[%0t] mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  // Offers one item from a falling edge and holds it until it is taken.
  // The prediction is queued at the accepting edge. Valid stays high on return.
  task automatic offer_item(bit restart, bit typed, logic [CAND_W-1:0] cand, bit last);
    wheel_result_t r;
    in_valid_i = 1'b1;
    restart_i = restart;
    do @(posedge clk_i); while (!(in_valid_i && !in_stall_o));
    r = advance_wheel(restart);
    if (typed) begin
      r.candidate = cand;
      r.last = last;
      r.ovf = 1'b0;
    end
    expected_results.push_back(r);
    @(negedge clk_i);
  endtask

  // Drops valid and keeps it low for a number of cycles, with noise on the payload.
  task automatic idle_cycles(int n);
    in_valid_i = 1'b0;
    repeat (n) begin
      restart_i = $urandom_range(0, 1);
      @(negedge clk_i);
    end
  endtask

  // Waits until every queued result has come out. Every item produces exactly
  // one result, so the block is idle once the queue is empty.
  task automatic wait_drained();
    in_valid_i = 1'b0;
    while (expected_results.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_wheel(logic [CFG_W-1:0] value);
    cfg_we_i = 1'b1;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    cfg_wdata_i = $urandom_range(0, 15);
    wheel_cfg = value;
  endtask

  // Output side: every accepted result is checked against the oldest expectation.
  always @(posedge clk_i) begin
    wheel_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result %0d with nothing expected", candidate_o));
      end else begin
        want = expected_results.pop_front();
        if (candidate_o !== want.candidate)
          report_mismatch($sformatf("candidate %0d, expected %0d", candidate_o,
                                    want.candidate));
        if (last_in_round_o !== want.last)
          report_mismatch($sformatf("last_in_round %b, expected %b for candidate %0d",
                                    last_in_round_o, want.last, want.candidate));
        if (overflow_o !== want.ovf)
          report_mismatch($sformatf("overflow %b, expected %b for candidate %0d",
                                    overflow_o, want.ovf, want.candidate));
      end
    end
  end

  // Hard stop in case the block hangs.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Receiver: switches between stall patterns every so often, and once holds
  // off for a long stretch so the block backs up into its input.
  initial begin
    int mode;
    int mode_left;
    mode = 0;
    mode_left = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_requested) begin
        out_stall_i = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_requested = 1'b0;
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 150);
      end
      mode_left--;
      case (mode)
        0: begin
          out_stall_i = 1'b0;
        end
        1: begin
          out_stall_i = ($urandom_range(0, 3) == 0);
        end
        2: begin
          out_stall_i = ($urandom_range(0, 3) != 0);
        end
        default: begin
          out_stall_i = ~out_stall_i;
        end
      endcase
    end
  end

  // Sender: directed table first, then random phases with a new wheel size each.
  initial begin
    int burst_left;
    bit restart;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    restart_i = 1'b0;
    mismatch_count = 0;
    cycle_count = 0;
    hold_requested = 1'b0;
    wheel_cfg = 4;
    clear_wheel();
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].wr) begin
        wait_drained();
        write_wheel(dir_rows[i].wval);
      end
      offer_item(dir_rows[i].rst, dir_rows[i].typed, dir_rows[i].cand, dir_rows[i].last);
    end
    wait_drained();

    // Random part. Most items just step the sequence; restarts are occasional so
    // the running value climbs well past the first few wheel blocks.
    burst_left = 0;
    for (int p = 0; p < PHASE_COUNT; p++) begin
      wait_drained();
      write_wheel($urandom_range(0, 15));
      if (p == 3) hold_requested = 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          // While the receiver holds off, keep offering items back to back.
          if (!hold_requested && $urandom_range(0, 3) != 0)
            idle_cycles($urandom_range(1, 12));
        end
        burst_left--;
        restart = (i == 0) ? $urandom_range(0, 1) : ($urandom_range(0, 15) == 0);
        offer_item(restart, 1'b0, '0, 1'b0);
      end
    end
    wait_drained();

    // Let any stray result show up before judging.
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/wcg_pkg.sv
hw/rtl/wcg_cell.sv
hw/rtl/wheel_candidate_generator_top.sv
verif/tb_wheel_candidate_generator_top.sv
